// ===== rtl/pswr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pswr_pkg
// Shared types and constants of the prefix sync word receiver.
// ----------------------------------------------------------------------------
package pswr_pkg;

    localparam int WORD_BITS   = 16;
    localparam int LIMIT_BITS  = 10;
    localparam int CAPWIN_BITS = 8;
    localparam int WAIT_BITS   = 9;
    localparam int AFTER_BITS  = 4;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [3:0]             SYNC_PREFIX  = 4'b1110;
    localparam logic [AFTER_BITS-1:0]  SYNC_DELAY   = 4'd12;
    localparam logic [WAIT_BITS-1:0]   WAIT_SAT     = 9'd256;
    localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET  = 10'd10;
    localparam logic [CAPWIN_BITS-1:0] WINDOW_RESET = 8'd8;

    // result queue between front and back
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_FOUND = 2'd0,
        KIND_EVENT = 2'd1,
        KIND_MATCH = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_TARGET = 2'd0,
        CFG_LIMIT  = 2'd1,
        CFG_WINDOW = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_kind                kind;
        logic [WORD_BITS-1:0] newer_word;
        logic [WORD_BITS-1:0] older_word;
        logic [WAIT_BITS-1:0] bits_waited;
        logic                 flag_level;
        logic                 finished;
        logic                 last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    w0;
        t_result    w1;
    } t_push;

    typedef struct packed {
        logic    not_empty;
        t_result head;
    } t_q_head;

endpackage
`default_nettype wire

// ===== rtl/pswr_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pswr_in_if
// Input channel: one stream bit and one pin sample per transfer.
// ----------------------------------------------------------------------------
interface pswr_in_if;
    logic valid;
    logic ready;
    logic stream_bit;
    logic pin_level;

    modport source (output valid, output stream_bit, output pin_level, input ready);
    modport sink (input valid, input stream_bit, input pin_level, output ready);
endinterface
`default_nettype wire

// ===== rtl/pswr_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pswr_out_if
// Output channel: one result record per transfer.
// ----------------------------------------------------------------------------
interface pswr_out_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      kind;
    logic [pswr_pkg::WORD_BITS-1:0]  newer_word;
    logic [pswr_pkg::WORD_BITS-1:0]  older_word;
    logic [pswr_pkg::WAIT_BITS-1:0]  bits_waited;
    logic                            flag_level;
    logic                            finished;
    logic                            last;

    modport source (
        output valid, output kind, output newer_word, output older_word,
        output bits_waited, output flag_level, output finished, output last,
        input ready
    );
    modport sink (
        input valid, input kind, input newer_word, input older_word,
        input bits_waited, input flag_level, input finished, input last,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/pswr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pswr_front
// Accepts stream bits, runs prefix sync, pin event and target match,
// and pushes zero, one or two result records into the queue.
// ----------------------------------------------------------------------------
module pswr_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [pswr_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [pswr_pkg::WORD_BITS-1:0]    i_cfg_data,
    input  wire logic                              i_room,
    pswr_in_if.sink                                i_in,
    output pswr_pkg::t_push                        o_push
);

    localparam int WB = pswr_pkg::WORD_BITS;

    logic [WB-1:0]                       r_target;
    logic [pswr_pkg::LIMIT_BITS-1:0]     r_limit;
    logic [pswr_pkg::CAPWIN_BITS-1:0]    r_capwin;

    logic [WB-1:0]                       r_win, n_win;
    logic                                r_armed, n_armed;
    logic [pswr_pkg::AFTER_BITS-1:0]     r_after, n_after;
    logic [2*WB-1:0]                     r_cache, n_cache;
    logic                                r_pending, n_pending;
    logic [pswr_pkg::WAIT_BITS-1:0]      r_since, n_since;
    logic                                r_parity, n_parity;
    logic                                r_flag, n_flag;
    logic [pswr_pkg::LIMIT_BITS-1:0]     r_ev_cnt, n_ev_cnt;
    logic [pswr_pkg::LIMIT_BITS-1:0]     r_match_cnt, n_match_cnt;

    logic fire;
    logic done;

    assign i_in.ready = i_room;
    assign fire = i_in.valid && i_in.ready;
    assign done = (r_ev_cnt >= r_limit) || (r_match_cnt >= r_limit);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_limit  <= pswr_pkg::LIMIT_RESET;
            r_capwin <= pswr_pkg::WINDOW_RESET;
        end else if (i_cfg_wr_en) begin
            case (pswr_pkg::t_cfg_idx'(i_cfg_index))
                pswr_pkg::CFG_TARGET: r_target <= i_cfg_data;
                pswr_pkg::CFG_LIMIT:  r_limit  <= i_cfg_data[pswr_pkg::LIMIT_BITS-1:0];
                pswr_pkg::CFG_WINDOW: r_capwin <= i_cfg_data[pswr_pkg::CAPWIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [pswr_pkg::WAIT_BITS-1:0] since_inc;
        logic                           found;
        logic                           rep_found;
        logic                           ev_hit;
        logic                           match_hit;
        logic                           fin_after;
        pswr_pkg::t_result              rec_a;
        pswr_pkg::t_result              rec_b;

        n_win       = r_win;
        n_armed     = r_armed;
        n_after     = r_after;
        n_cache     = r_cache;
        n_pending   = r_pending;
        n_since     = r_since;
        n_parity    = r_parity;
        n_flag      = r_flag;
        n_ev_cnt    = r_ev_cnt;
        n_match_cnt = r_match_cnt;
        since_inc   = r_since;
        found       = 1'b0;
        rep_found   = 1'b0;
        ev_hit      = 1'b0;
        match_hit   = 1'b0;

        if (fire && !done) begin
            since_inc = (r_since < pswr_pkg::WAIT_SAT) ? r_since + 1'b1 : r_since;
            n_since   = since_inc;
            n_win     = {r_win[WB-2:0], i_in.stream_bit};

            if (n_win[3:0] == pswr_pkg::SYNC_PREFIX) begin
                n_armed = 1'b1;
                n_after = '0;
            end else if (r_armed) begin
                n_after = r_after + 1'b1;
                if (n_after == pswr_pkg::SYNC_DELAY) begin
                    n_armed = 1'b0;
                    found   = 1'b1;
                end
            end

            if (found) begin
                n_cache = {r_cache[WB-1:0], n_win};
                if (r_pending && (since_inc <= {1'b0, r_capwin})) begin
                    rep_found = 1'b1;
                    n_pending = 1'b0;
                end
            end

            // pin level differing from the parity is the expected edge
            if (i_in.pin_level != r_parity) begin
                ev_hit    = 1'b1;
                n_parity  = ~r_parity;
                n_ev_cnt  = r_ev_cnt + 1'b1;
                n_pending = 1'b1;
                n_since   = '0;
            end else if (n_win == r_target) begin
                match_hit   = 1'b1;
                n_flag      = ~r_flag;
                n_match_cnt = r_match_cnt + 1'b1;
            end
        end

        fin_after = (n_ev_cnt >= r_limit) || (n_match_cnt >= r_limit);

        rec_a.kind        = pswr_pkg::KIND_FOUND;
        rec_a.newer_word  = n_win;
        rec_a.older_word  = '0;
        rec_a.bits_waited = since_inc;
        rec_a.flag_level  = n_flag;
        rec_a.finished    = fin_after;
        rec_a.last        = !(ev_hit || match_hit);

        rec_b.kind        = ev_hit ? pswr_pkg::KIND_EVENT : pswr_pkg::KIND_MATCH;
        rec_b.newer_word  = ev_hit ? n_cache[WB-1:0] : r_target;
        rec_b.older_word  = ev_hit ? n_cache[2*WB-1:WB] : '0;
        rec_b.bits_waited = '0;
        rec_b.flag_level  = n_flag;
        rec_b.finished    = fin_after;
        rec_b.last        = 1'b1;

        o_push = '0;
        if (rep_found) begin
            o_push.w0    = rec_a;
            o_push.w1    = rec_b;
            o_push.count = (ev_hit || match_hit) ? 2'd2 : 2'd1;
        end else if (ev_hit || match_hit) begin
            o_push.w0    = rec_b;
            o_push.count = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= '0;
            r_armed     <= 1'b0;
            r_after     <= '0;
            r_cache     <= '0;
            r_pending   <= 1'b0;
            r_since     <= '0;
            r_parity    <= 1'b0;
            r_flag      <= 1'b0;
            r_ev_cnt    <= '0;
            r_match_cnt <= '0;
        end else begin
            r_win       <= n_win;
            r_armed     <= n_armed;
            r_after     <= n_after;
            r_cache     <= n_cache;
            r_pending   <= n_pending;
            r_since     <= n_since;
            r_parity    <= n_parity;
            r_flag      <= n_flag;
            r_ev_cnt    <= n_ev_cnt;
            r_match_cnt <= n_match_cnt;
        end
    end

    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> (o_push.count == 2'd0))
        else $error("finished block produced a result");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count == 2'd2) |->
            (o_push.w0.kind == pswr_pkg::KIND_FOUND && !o_push.w0.last && o_push.w1.last))
        else $error("two results out of order");

    a_since_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_since <= pswr_pkg::WAIT_SAT)
        else $error("bit counter beyond saturation");

endmodule
`default_nettype wire

// ===== rtl/pswr_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pswr_queue
// Short result queue: takes up to two records a cycle, gives one.
// ----------------------------------------------------------------------------
module pswr_queue (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire pswr_pkg::t_push i_push,
    input  wire logic    i_pop,
    output logic         o_room,
    output pswr_pkg::t_q_head o_head
);

    localparam int PB = pswr_pkg::Q_PTR_BITS;
    localparam int CB = pswr_pkg::Q_CNT_BITS;

    pswr_pkg::t_result r_mem [pswr_pkg::Q_DEPTH];
    logic [PB-1:0]     r_wr, n_wr;
    logic [PB-1:0]     r_rd, n_rd;
    logic [CB-1:0]     r_count, n_count;

    // room for a full pair keeps the front from ever overrunning
    assign o_room           = r_count <= CB'(pswr_pkg::Q_DEPTH - 2);
    assign o_head.not_empty = r_count != '0;
    assign o_head.head      = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr + PB'(i_push.count);
        n_rd    = r_rd + PB'(i_pop);
        n_count = r_count + CB'(i_push.count) - CB'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.w0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + PB'(1)] <= i_push.w1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CB'(pswr_pkg::Q_DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> o_room)
        else $error("push without room");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head.not_empty)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== rtl/pswr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pswr_back
// Drains the result queue into the output register of the result channel.
// ----------------------------------------------------------------------------
module pswr_back (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire pswr_pkg::t_q_head i_head,
    output logic              o_pop,
    pswr_out_if.source        o_out
);

    logic              r_valid;
    pswr_pkg::t_result r_data;

    assign o_pop = i_head.not_empty && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_head.head;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.kind        = r_data.kind;
    assign o_out.newer_word  = r_data.newer_word;
    assign o_out.older_word  = r_data.older_word;
    assign o_out.bits_waited = r_data.bits_waited;
    assign o_out.flag_level  = r_data.flag_level;
    assign o_out.finished    = r_data.finished;
    assign o_out.last        = r_data.last;

endmodule
`default_nettype wire

// ===== rtl/prefix_sync_word_receiver_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prefix_sync_word_receiver_core
// Prefix synced word receiver with pin event capture and target match flag.
// ----------------------------------------------------------------------------
// each result is registered in the queue, then in the output register
// throughput: one input bit per cycle while the queue has room; output gives
//   one result per cycle while ready is high, so a pair goes out in turn
// the four-entry result queue takes input only with room for two results
// synchronous active-low reset loads defaults, clears all but stored records
module prefix_sync_word_receiver_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [pswr_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [pswr_pkg::WORD_BITS-1:0]    i_cfg_data,
    pswr_in_if.sink                                i_in,
    pswr_out_if.source                             o_out
);

    pswr_pkg::t_push   push;
    pswr_pkg::t_q_head head;
    logic              room;
    logic              pop;

    pswr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_room      (room),
        .i_in        (i_in),
        .o_push      (push)
    );

    pswr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_room  (room),
        .o_head  (head)
    );

    pswr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

// ===== tb/prefix_sync_word_receiver_core_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prefix_sync_word_receiver_core_tb
// Self-checking bench for the prefix sync word receiver. It drives a serial
// bit stream with framed words, noise and pin events, and predicts every
// result. Each result is compared field by field, and random idles and a long
// output stall press on both handshakes.
// ----------------------------------------------------------------------------
module prefix_sync_word_receiver_core_tb;

    localparam int IDLE_PCT     = 9;
    localparam int SETTLE       = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 400;
    localparam int LONG_HOLD    = 300;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_cfg_wr_en;
    logic [pswr_pkg::CFG_IDX_BITS-1:0] i_cfg_index;
    logic [pswr_pkg::WORD_BITS-1:0]    i_cfg_data;

    pswr_in_if  in_ch ();
    pswr_out_if out_ch ();

    prefix_sync_word_receiver_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predicted receiver state and register copies
    logic [pswr_pkg::WORD_BITS-1:0]   cfg_target  = '0;
    logic [pswr_pkg::LIMIT_BITS-1:0]  cfg_limit   = pswr_pkg::LIMIT_RESET;
    logic [pswr_pkg::CAPWIN_BITS-1:0] cfg_capwin  = pswr_pkg::WINDOW_RESET;
    logic [pswr_pkg::WORD_BITS-1:0]   rx_window   = '0;
    logic                             rx_armed    = 1'b0;
    logic [pswr_pkg::AFTER_BITS-1:0]  rx_after    = '0;
    logic [pswr_pkg::WORD_BITS-1:0]   cache_newer = '0;
    logic [pswr_pkg::WORD_BITS-1:0]   cache_older = '0;
    logic                             capture_on  = 1'b0;
    logic [pswr_pkg::WAIT_BITS-1:0]   since_event = '0;
    logic                             rx_parity   = 1'b0;
    logic                             rx_flag     = 1'b0;
    logic [pswr_pkg::LIMIT_BITS-1:0]  event_cnt   = '0;
    logic [pswr_pkg::LIMIT_BITS-1:0]  match_cnt   = '0;

    pswr_pkg::t_result awaited_reports[$];
    int      errors        = 0;
    int      items_sent    = 0;
    int      hold_request  = 0;
    int      hold_left     = 0;
    bit      idle_on       = 1'b1;
    logic    pin_now       = 1'b0;
    int unsigned cycle_count = 0;

    function automatic logic receiver_stopped();
        return (event_cnt >= cfg_limit) || (match_cnt >= cfg_limit);
    endfunction

    task automatic advance_receiver(input logic sbit, input logic pin);
        pswr_pkg::t_result reps[$];
        pswr_pkg::t_result rep;
        logic    found_word;
        logic [pswr_pkg::WORD_BITS-1:0] word;
        if (receiver_stopped()) return;
        found_word = 1'b0;
        word = '0;
        if (since_event < pswr_pkg::WAIT_SAT) since_event++;
        rx_window = {rx_window[pswr_pkg::WORD_BITS-2:0], sbit};
        if (rx_window[3:0] == pswr_pkg::SYNC_PREFIX) begin
            rx_armed = 1'b1;
            rx_after = '0;
        end else if (rx_armed) begin
            rx_after = rx_after + 1'b1;
            if (rx_after == pswr_pkg::SYNC_DELAY) begin
                rx_armed = 1'b0;
                found_word = 1'b1;
                word = rx_window;
            end
        end
        if (found_word) begin
            cache_older = cache_newer;
            cache_newer = word;
            if (capture_on && since_event <= cfg_capwin) begin
                rep = '0;
                rep.kind = pswr_pkg::KIND_FOUND;
                rep.newer_word = word;
                rep.bits_waited = since_event;
                reps.push_back(rep);
                capture_on = 1'b0;
            end
        end
        // rising level first, then falling, and so on
        if (pin != rx_parity) begin
            rx_parity = ~rx_parity;
            event_cnt++;
            rep = '0;
            rep.kind = pswr_pkg::KIND_EVENT;
            rep.newer_word = cache_newer;
            rep.older_word = cache_older;
            reps.push_back(rep);
            capture_on = 1'b1;
            since_event = '0;
        end else if (rx_window == cfg_target) begin
            rx_flag = ~rx_flag;
            match_cnt++;
            rep = '0;
            rep.kind = pswr_pkg::KIND_MATCH;
            rep.newer_word = cfg_target;
            reps.push_back(rep);
        end
        foreach (reps[k]) begin
            reps[k].flag_level = rx_flag;
            reps[k].finished = receiver_stopped();
            reps[k].last = (k == reps.size() - 1);
            awaited_reports.push_back(reps[k]);
        end
    endtask

    task automatic send_bit(input logic sbit, input logic pin);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.stream_bit <= sbit;
        in_ch.pin_level  <= pin;
        do @(posedge i_clk); while (!in_ch.ready);
        advance_receiver(sbit, pin);
        items_sent++;
        @(negedge i_clk);
    endtask

    // msb first, explicit pin level per bit
    task automatic send_pattern(input logic [15:0] bits, input logic [15:0] pins);
        int i;
        for (i = 15; i >= 0; i--) begin
            pin_now = pins[i];
            send_bit(bits[i], pin_now);
        end
    endtask

    // top count bits msb first, pin flips at rate per mille
    task automatic send_stream_bits(input logic [15:0] bits, input int count,
                                    input int rate);
        int i;
        for (i = 15; i > 15 - count; i--) begin
            if ($urandom_range(999) < rate) pin_now = ~pin_now;
            send_bit(bits[i], pin_now);
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (awaited_reports.size() != 0);
    endtask

    task automatic write_reg(input pswr_pkg::t_cfg_idx idx,
                             input logic [pswr_pkg::WORD_BITS-1:0] value);
        wait_drained();
        // items that cause no result may still be in flight
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            pswr_pkg::CFG_TARGET: cfg_target = value;
            pswr_pkg::CFG_LIMIT:  cfg_limit  = value[pswr_pkg::LIMIT_BITS-1:0];
            pswr_pkg::CFG_WINDOW: cfg_capwin = value[pswr_pkg::CAPWIN_BITS-1:0];
            default: ;
        endcase
    endtask

    // reset target is zero and so is the window
    task automatic test_zero_target();
        send_bit(1'b0, 1'b0);
    endtask

    task automatic test_capture_window();
        write_reg(pswr_pkg::CFG_TARGET, 16'hFFFF);
        write_reg(pswr_pkg::CFG_WINDOW, 16'd12);
        // rise, fall restarts capture, word lands at exactly 12 bits with a rise
        send_pattern(16'hE5A5, 16'hE001);
        // fall at bit 3, word lands at 13 bits: capture expired
        send_pattern(16'hE96B, 16'hC000);
    endtask

    task automatic test_finish_limit();
        write_reg(pswr_pkg::CFG_LIMIT, 16'(event_cnt + 1'b1));
        pin_now = ~pin_now;
        send_bit(1'b1, pin_now);
        send_stream_bits(16'($urandom()), 1, 500);
        write_reg(pswr_pkg::CFG_LIMIT, 16'd0);
        send_stream_bits(16'($urandom()), 1, 500);
        write_reg(pswr_pkg::CFG_LIMIT, 16'd1);
        send_stream_bits(16'($urandom()), 1, 500);
    endtask

    task automatic run_phase(input int n_items, input int rate);
        int stop_at;
        int pick;
        int len;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_stream_bits({pswr_pkg::SYNC_PREFIX, 12'($urandom())}, 16, rate);
            end else if (pick < 80) begin
                send_stream_bits(cfg_target, 16, rate);
            end else if (pick < 90) begin
                // cut short, next prefix restarts the count
                len = $urandom_range(11);
                send_stream_bits({pswr_pkg::SYNC_PREFIX, 12'($urandom())}, 4 + len, rate);
            end else begin
                len = $urandom_range(1, 8);
                send_stream_bits(16'($urandom()), len, rate);
            end
        end
    endtask

    task automatic test_random_settings();
        write_reg(pswr_pkg::CFG_LIMIT, 16'd1023);
        write_reg(pswr_pkg::CFG_TARGET, 16'h0000);
        write_reg(pswr_pkg::CFG_WINDOW, 16'd255);
        run_phase(PHASE_ITEMS, 30);

        write_reg(pswr_pkg::CFG_TARGET, 16'($urandom()));
        write_reg(pswr_pkg::CFG_WINDOW, 16'd0);
        idle_on = 1'b0;
        run_phase(PHASE_ITEMS, 30);
        idle_on = 1'b1;

        // rare pin changes let the bit counter saturate
        write_reg(pswr_pkg::CFG_TARGET, 16'($urandom()));
        write_reg(pswr_pkg::CFG_WINDOW, 16'($urandom_range(255)));
        run_phase(PHASE_ITEMS, 3);

        write_reg(pswr_pkg::CFG_TARGET, 16'hFFFF);
        write_reg(pswr_pkg::CFG_WINDOW, 16'($urandom_range(8, 40)));
        run_phase(PHASE_ITEMS, 60);
    endtask

    task automatic test_backpressure();
        int i;
        hold_request = LONG_HOLD;
        for (i = 0; i < 40; i++) begin
            pin_now = ~pin_now;
            send_bit(1'($urandom_range(1)), pin_now);
        end
        wait_drained();
    endtask

    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_reports
        pswr_pkg::t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (awaited_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual kind %0d word %h",
                         $time, out_ch.kind, out_ch.newer_word);
            end else begin
                want = awaited_reports.pop_front();
                check_field("kind", want.kind, out_ch.kind);
                check_field("newer_word", want.newer_word, out_ch.newer_word);
                check_field("older_word", want.older_word, out_ch.older_word);
                check_field("bits_waited", want.bits_waited, out_ch.bits_waited);
                check_field("flag_level", want.flag_level, out_ch.flag_level);
                check_field("finished", want.finished, out_ch.finished);
                check_field("last", want.last, out_ch.last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_wr_en      = 1'b0;
        i_cfg_index      = pswr_pkg::CFG_TARGET;
        i_cfg_data       = '0;
        in_ch.valid      = 1'b0;
        in_ch.stream_bit = 1'b0;
        in_ch.pin_level  = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_zero_target();
        test_capture_window();
        test_finish_limit();
        test_random_settings();
        test_backpressure();

        wait_drained();
        repeat (SETTLE) @(negedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
